// ===== sv/ntcl_pkg.sv =====
// shared types, constants and the log2 table of the thermistor linearizer
package ntcl_pkg;

  localparam int unsigned NumW = 56;   // dividend: B * log2(e) constant
  localparam int unsigned DenW = 24;   // divisor: log2(R/A) in Q.16
  localparam int unsigned LgW  = 23;   // log2 result of one value, Q.16
  localparam int unsigned L2W  = 25;   // signed sum of four log2 terms

  localparam logic [23:0] KelvinK     = 24'd9454846;
  localparam logic [15:0] InvalidCenti = 16'h954D;
  localparam logic [58:0] BiasConst   = 59'd3920512;
  localparam logic [58:0] BiasedMax   = 59'd6144255;
  localparam logic [15:0] LimitCenti  = 16'd12000;

  typedef struct packed {
    logic vld;
    logic inv;
  } ntcl_tag_t;

  typedef enum logic [2:0] {
    RegA      = 3'd0,
    RegB      = 3'd1,
    RegC      = 3'd2,
    RegQuad   = 3'd3,
    RegGain   = 3'd4,
    RegOffset = 3'd5,
    RegSeries = 3'd6
  } ntcl_reg_e;

  // log2(1 + i/32) in Q.16
  function automatic logic [16:0] lg_tab(input logic [5:0] idx);
    logic [16:0] v;
    unique case (idx)
      6'd0:  v = 17'd0;
      6'd1:  v = 17'd2909;
      6'd2:  v = 17'd5732;
      6'd3:  v = 17'd8473;
      6'd4:  v = 17'd11136;
      6'd5:  v = 17'd13727;
      6'd6:  v = 17'd16248;
      6'd7:  v = 17'd18704;
      6'd8:  v = 17'd21098;
      6'd9:  v = 17'd23433;
      6'd10: v = 17'd25711;
      6'd11: v = 17'd27936;
      6'd12: v = 17'd30109;
      6'd13: v = 17'd32234;
      6'd14: v = 17'd34312;
      6'd15: v = 17'd36346;
      6'd16: v = 17'd38336;
      6'd17: v = 17'd40286;
      6'd18: v = 17'd42196;
      6'd19: v = 17'd44068;
      6'd20: v = 17'd45904;
      6'd21: v = 17'd47705;
      6'd22: v = 17'd49472;
      6'd23: v = 17'd51207;
      6'd24: v = 17'd52911;
      6'd25: v = 17'd54584;
      6'd26: v = 17'd56229;
      6'd27: v = 17'd57845;
      6'd28: v = 17'd59434;
      6'd29: v = 17'd60997;
      6'd30: v = 17'd62534;
      6'd31: v = 17'd64047;
      6'd32: v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/ntc_thermistor_linearizer.sv =====
// top level of the ntc thermistor linearizer: config registers, log sum, output stage
//
//   channel   direction  signals                                  transaction when
//   in        input      in_valid_i, in_ready_o, raw_sample_i     in_valid_i & in_ready_o
//   out       output     out_valid_o, out_ready_i, temp_centi_o,  out_valid_o & out_ready_i
//                        temp_valid_o
//   cfg       input      cfg_we_i, cfg_idx_i, cfg_data_i          cfg_we_i
//
// one transaction enters per cycle while the pipe is not stalled; the stages are
// 7 front stages, 3 log2 stages, 1 log sum, 1 divider load, 56 divider stages and
// 2 output stages, the depth set by the one-bit-per-stage divider for B*k / log2(R/A)
// reset clears the valid bits and loads the register defaults; data carries no reset
// the whole pipe advances together and holds only while the output register is
// full and not taken, so a stall loses and repeats nothing
module ntc_thermistor_linearizer #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] raw_sample_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [15:0]     temp_centi_o,
  output logic                   temp_valid_o,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [31:0]            cfg_data_i
);
  import ntcl_pkg::*;

  // configuration registers
  logic [31:0]        a_q, b_q;
  logic [23:0]        c_q, series_q;
  logic signed [31:0] quad_q;
  logic [17:0]        gain_q;
  logic signed [23:0] offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q      <= 32'd1024;
      b_q      <= 32'd1199207;
      c_q      <= 24'd13410;
      quad_q   <= '0;
      gain_q   <= 18'd63898;
      offset_q <= 24'sd262193;
      series_q <= 24'd100000;
    end else if (cfg_we_i) begin
      unique case (ntcl_reg_e'(cfg_idx_i))
        RegA:      a_q      <= cfg_data_i;
        RegB:      b_q      <= cfg_data_i;
        RegC:      c_q      <= cfg_data_i[23:0];
        RegQuad:   quad_q   <= cfg_data_i;
        RegGain:   gain_q   <= cfg_data_i[17:0];
        RegOffset: offset_q <= cfg_data_i[23:0];
        RegSeries: series_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // whole pipe advances unless the output register holds an untaken result
  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  ntcl_tag_t in_tag;
  assign in_tag = '{vld: in_valid_i, inv: (a_q == '0) | (series_q == '0)};

  // polynomial correction and divider terms
  ntcl_tag_t          fr_tag;
  logic signed [63:0] poly, den;

  ntcl_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i, .rst_ni, .en_i(adv), .tag_i(in_tag), .sample_i(raw_sample_i),
    .quad_i(quad_q), .gain_i(gain_q), .offset_i(offset_q),
    .tag_o(fr_tag), .poly_o(poly), .den_o(den)
  );

  // four log2 units in parallel; invalid values only feed results that get discarded
  logic [LgW-1:0] lg_series, lg_poly, lg_den, lg_a;

  ntcl_lg #(.W(24)) u_lg_series (.clk_i, .en_i(adv), .v_i(series_q), .lg_o(lg_series));
  ntcl_lg #(.W(64)) u_lg_poly (.clk_i, .en_i(adv), .v_i(poly), .lg_o(lg_poly));
  ntcl_lg #(.W(64)) u_lg_den (.clk_i, .en_i(adv), .v_i(den), .lg_o(lg_den));
  ntcl_lg #(.W(32)) u_lg_a (.clk_i, .en_i(adv), .v_i(a_q), .lg_o(lg_a));

  ntcl_tag_t lgt_q [3];
  ntcl_tag_t l2t_q;
  logic signed [L2W-1:0] l2_w;
  logic [DenW-1:0]       l2_q;

  // log2(R/A) = log2(series) + log2(poly) - log2(den) - log2(A) + 16
  assign l2_w = L2W'(lg_series) + L2W'(lg_poly) - L2W'(lg_den) - L2W'(lg_a)
              + L2W'(32'd1048576);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) lgt_q[k] <= '0;
      l2t_q <= '0;
    end else if (adv) begin
      lgt_q[0] <= fr_tag;
      lgt_q[1] <= lgt_q[0];
      lgt_q[2] <= lgt_q[1];
      // ratio not above one would put the temperature far below range
      l2t_q <= '{vld: lgt_q[2].vld, inv: lgt_q[2].inv | l2_w[L2W-1] | (l2_w == '0)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) l2_q <= l2_w[DenW-1:0];
  end

  // q8 = B * 25600*log2(e) / log2(R/A)
  ntcl_tag_t       dv_tag;
  logic [NumW-1:0] quo;
  logic [NumW-1:0] num_w;
  assign num_w = NumW'(b_q) * NumW'(KelvinK);

  ntcl_div u_div (
    .clk_i, .rst_ni, .en_i(adv), .tag_i(l2t_q), .num_i(num_w), .den_i(l2_q),
    .tag_o(dv_tag), .quo_o(quo)
  );

  // biased = q8 - 100*C - 273.15 K offset + rounding + range bias
  ntcl_tag_t          bt_q;
  logic signed [58:0] biased_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bt_q <= '0;
    end else if (adv) begin
      bt_q <= dv_tag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      biased_q <= $signed({3'b0, quo} - 59'(c_q) * 59'd100 - BiasConst);
    end
  end

  // output register
  logic        ok_w;
  logic [15:0] temp_q;
  logic        tvalid_q;

  assign ok_w = !bt_q.inv && !biased_q[58] && (59'(biased_q) <= BiasedMax);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= bt_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      temp_q   <= ok_w ? (biased_q[23:8] - LimitCenti) : InvalidCenti;
      tvalid_q <= ok_w;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign temp_centi_o = temp_q;
  assign temp_valid_o = tvalid_q;

endmodule

// ===== sv/ntcl_front.sv =====
// front pipeline: divide by three, adc correction polynomial, divider bottom
module ntcl_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  ntcl_pkg::ntcl_tag_t      tag_i,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  input  logic signed [31:0]       quad_i,
  input  logic [17:0]              gain_i,
  input  logic signed [23:0]       offset_i,
  output ntcl_pkg::ntcl_tag_t      tag_o,
  output logic signed [63:0]       poly_o,
  output logic signed [63:0]       den_o
);
  import ntcl_pkg::*;

  localparam int NStg = 7;
  localparam logic signed [63:0] Fs8 =
      64'(((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1) * 64'sd256);

  ntcl_tag_t tag_q [NStg];

  logic [31:0]        n_w;
  logic [63:0]        prod_q;
  logic [30:0]        x8_q, x8b_q, x8c_q;
  logic signed [63:0] qx_w, xx_w, xc_w;
  logic signed [63:0] m1_q, m2_q;
  logic [48:0]        g_q;
  logic [32:0]        gs_q, gs2_q;
  logic signed [31:0] t1_q;
  logic signed [63:0] poly_q, poly2_q, den_q, den_w;

  assign n_w  = 32'(sample_i[SAMPLE_BITS-2:0]) << 8;
  assign qx_w = 64'(quad_i);
  assign xx_w = {33'b0, x8_q};
  assign xc_w = {33'b0, x8c_q};
  assign den_w = Fs8 - poly_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NStg; k++) tag_q[k] <= '0;
    end else if (en_i) begin
      tag_q[0] <= '{vld: tag_i.vld, inv: tag_i.inv | sample_i[SAMPLE_BITS-1]};
      for (int k = 1; k < NStg - 1; k++) tag_q[k] <= tag_q[k-1];
      tag_q[NStg-1] <= '{vld: tag_q[NStg-2].vld,
                         inv: tag_q[NStg-2].inv | (poly_q <= 64'sd0) | (den_w <= 64'sd0)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= 64'(n_w) * 64'(32'hAAAAAAAB);      // floor(n/3) = prod >> 33
      x8_q    <= prod_q[63:33];
      m1_q    <= qx_w * xx_w;
      g_q     <= 49'(gain_i) * 49'(x8_q);
      x8b_q   <= x8_q;
      t1_q    <= m1_q[63:32];
      gs_q    <= g_q[48:16];
      x8c_q   <= x8b_q;
      m2_q    <= 64'(t1_q) * xc_w;
      gs2_q   <= gs_q;
      // all terms signed so the quadratic term floors
      poly_q  <= (m2_q >>> 8) + $signed(64'(gs2_q)) + 64'(offset_i);
      poly2_q <= poly_q;
      den_q   <= den_w;
    end
  end

  assign tag_o  = tag_q[NStg-1];
  assign poly_o = poly2_q;
  assign den_o  = den_q;

endmodule

// ===== sv/ntcl_lg.sv =====
// three-stage log2 unit: msb search, table lookup, linear interpolation
module ntcl_lg #(
  parameter int W = 64
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [W-1:0]              v_i,
  output logic [ntcl_pkg::LgW-1:0]  lg_o
);
  import ntcl_pkg::*;

  localparam int EW = $clog2(W);

  logic [EW-1:0]  e_w, e_q, e2_q;
  logic [W-1:0]   v_q;
  logic [W+15:0]  wide_w;
  logic [15:0]    f_w;
  logic [16:0]    t0_q, t1_w;
  logic [11:0]    dt_q;
  logic [10:0]    r_q;
  logic [22:0]    prod_w;
  logic [LgW-1:0] lg_q;

  always_comb begin
    e_w = '0;
    for (int k = 0; k < W; k++) begin
      if (v_i[k]) e_w = EW'(k);
    end
  end

  assign wide_w = {v_q, 16'b0} >> e_q;
  assign f_w    = wide_w[15:0];
  assign t1_w   = lg_tab({1'b0, f_w[15:11]} + 6'd1);
  assign prod_w = 23'(dt_q) * 23'(r_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q  <= e_w;
      v_q  <= v_i;
      e2_q <= e_q;
      t0_q <= lg_tab({1'b0, f_w[15:11]});
      dt_q <= 12'(t1_w - lg_tab({1'b0, f_w[15:11]}));
      r_q  <= f_w[10:0];
      lg_q <= (LgW'(e2_q) << 16) + LgW'(t0_q) + LgW'(prod_w[22:11]);
    end
  end

  assign lg_o = lg_q;

endmodule

// ===== sv/ntcl_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module ntcl_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  ntcl_pkg::ntcl_tag_t        tag_i,
  input  logic [ntcl_pkg::NumW-1:0]  num_i,
  input  logic [ntcl_pkg::DenW-1:0]  den_i,
  output ntcl_pkg::ntcl_tag_t        tag_o,
  output logic [ntcl_pkg::NumW-1:0]  quo_o
);
  import ntcl_pkg::*;

  ntcl_tag_t       tag_q [NumW+1];
  logic [NumW-1:0] nq_q  [NumW+1];   // dividend bits shift out, quotient bits in
  logic [DenW-1:0] rem_q [NumW+1];
  logic [DenW-1:0] d_q   [NumW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NumW; k++) tag_q[k] <= '0;
    end else if (en_i) begin
      tag_q[0] <= tag_i;
      for (int k = 1; k <= NumW; k++) tag_q[k] <= tag_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nq_q[0]  <= num_i;
      rem_q[0] <= '0;
      d_q[0]   <= den_i;
    end
  end

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic [DenW:0] trial_w;
    logic          ge_w;
    logic [DenW:0] diff_w;
    assign trial_w = {rem_q[k], nq_q[k][NumW-1]};
    assign ge_w    = trial_w >= {1'b0, d_q[k]};
    assign diff_w  = trial_w - {1'b0, d_q[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge_w ? diff_w[DenW-1:0] : trial_w[DenW-1:0];
        nq_q[k+1]  <= {nq_q[k][NumW-2:0], ge_w};
        d_q[k+1]   <= d_q[k];
      end
    end
  end

  assign tag_o = tag_q[NumW];
  assign quo_o = nq_q[NumW];

endmodule

// ===== verif/tb.sv =====
// testbench for the ntc thermistor linearizer: golden-model scoreboard with random traffic
module tb;
  import ntcl_pkg::*;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // dut ports
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] raw_sample_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic signed [15:0] temp_centi_o;
  logic        temp_valid_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  ntc_thermistor_linearizer #(.SAMPLE_BITS(16)) dut (.*);

  // shadow copy of the coefficient registers
  logic [31:0] a_q16, b_q8, quad_q32;
  logic [23:0] c_q8, offset_q8, series;
  logic [17:0] gain_q16;

  typedef struct packed {
    logic signed [15:0] centi;
    logic               vld;
  } temp_t;
  temp_t temp_queue[$];

  int  n_errors = 0;
  int  n_temps = 0;
  int  n_valid_temps = 0;
  int  n_sent = 0;
  bit  rx_idle_en = 1'b1;
  bit  tx_idle_en = 1'b1;
  int  rx_hold = 0;

  localparam int unsigned LgTab[33] = '{
    0, 2909, 5732, 8473, 11136, 13727, 16248, 18704,
    21098, 23433, 25711, 27936, 30109, 32234, 34312, 36346,
    38336, 40286, 42196, 44068, 45904, 47705, 49472, 51207,
    52911, 54584, 56229, 57845, 59434, 60997, 62534, 64047, 65536};

  function automatic longint log2_q16(longint unsigned v);
    int e;
    longint unsigned m;
    int unsigned f, i, r;
    e = 63;
    while (e > 0 && v[e] == 1'b0) e--;
    if (e >= 16) m = v >> (e - 16);
    else m = v << (16 - e);
    f = m[15:0];
    i = f >> 11;
    r = f & 32'h7FF;
    return longint'(e) * 65536 + LgTab[i] + (((LgTab[i+1] - LgTab[i]) * r) >> 11);
  endfunction

  // arithmetic shift right by s floors for negative values
  function automatic temp_t convert_sample(logic [15:0] raw);
    temp_t t;
    longint p, x8, t1, poly8, den8, l2, t8, biased;
    longint unsigned q8;
    t.centi = InvalidCenti;
    t.vld = 1'b0;
    p = longint'($signed(raw));
    if (p < 0 || a_q16 == 0 || series == 0) return t;
    x8 = (p * 256) / 3;
    t1 = (longint'($signed(quad_q32)) * x8) >>> 32;
    poly8 = ((t1 * x8) >>> 8) + ((longint'(gain_q16) * x8) >>> 16)
          + longint'($signed(offset_q8));
    den8 = 32767 * 256 - poly8;
    if (poly8 <= 0 || den8 <= 0) return t;
    l2 = log2_q16(series) + log2_q16(poly8) - log2_q16(den8) - log2_q16(a_q16)
       + 64'd16 * 65536;
    if (l2 <= 0) return t;
    q8 = (longint'(b_q8) * longint'(KelvinK)) / longint'(l2);
    t8 = longint'(q8) - longint'(c_q8) * 100 - 27315 * 256;
    biased = t8 + 128 + 12000 * 256;
    if (biased < 0 || biased > 12000 * 512 + 255) return t;
    t.centi = 16'((biased >>> 8) - 12000);
    t.vld = 1'b1;
    return t;
  endfunction

  // one register write, only issued while the pipe is empty
  task automatic write_reg(ntcl_reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegA:      a_q16 = val;
      RegB:      b_q8 = val;
      RegC:      c_q8 = val[23:0];
      RegQuad:   quad_q32 = val;
      RegGain:   gain_q16 = val[17:0];
      RegOffset: offset_q8 = val[23:0];
      RegSeries: series = val[23:0];
      default: ;
    endcase
  endtask

  // send one sample transaction, prediction is taken at acceptance
  // valid stays up afterwards so the next transaction can follow directly
  task automatic send_sample(logic [15:0] raw);
    int gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_sample_i <= raw;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    temp_queue.push_back(convert_sample(raw));
    n_sent++;
    @(negedge clk_i);
  endtask

  // wait until the pipe has drained, then past the full latency
  task automatic drain_pipe();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (temp_queue.size() != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (80) @(negedge clk_i);
  endtask

  // random sample biased toward the useful positive range
  function automatic logic [15:0] rand_sample();
    if ($urandom_range(0, 9) < 8) return 16'($urandom_range(0, 32767));
    return 16'($urandom);
  endfunction

  // receiver: random stalls or a long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ready_i <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      rx_hold <= $urandom_range(0, 4);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    temp_t exp_t;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (temp_queue.size() == 0) begin
        $display("%0t: unexpected result temp %0d valid %0b", $time,
                 temp_centi_o, temp_valid_o);
        n_errors++;
      end else begin
        exp_t = temp_queue.pop_front();
        n_temps++;
        if (exp_t.vld) n_valid_temps++;
        if (exp_t.centi !== temp_centi_o) begin
          $display("%0t: temp_centi expected %0d actual %0d", $time,
                   exp_t.centi, temp_centi_o);
          n_errors++;
        end
        if (exp_t.vld !== temp_valid_o) begin
          $display("%0t: temp_valid expected %0b actual %0b", $time,
                   exp_t.vld, temp_valid_o);
          n_errors++;
        end
      end
    end
  end

  task automatic test_defaults();
    logic [15:0] dir[12];
    dir = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF, 16'd100,
            16'd1000, 16'd5000, 16'd16384, 16'd25000, 16'd30000, 16'd32000};
    foreach (dir[i]) send_sample(dir[i]);
    drain_pipe();
  endtask

  task automatic test_special_regs();
    write_reg(RegA, 32'd0);           // zero a forces invalid
    send_sample(16'd16000);
    drain_pipe();
    write_reg(RegA, 32'hFFFF_FFFF);   // r/a below one
    send_sample(16'd16000);
    drain_pipe();
    write_reg(RegA, 32'd1024);
    write_reg(RegSeries, 24'd1);
    write_reg(RegOffset, 32'h0080_0000);
    send_sample(16'd100);
    send_sample(16'd32767);
    drain_pipe();
    write_reg(RegSeries, 24'hFF_FFFF);
    write_reg(RegOffset, 32'h007F_FFFF);
    write_reg(RegGain, 18'h3FFFF);
    write_reg(RegQuad, 32'h8000_0000);
    write_reg(RegB, 32'hFFFF_FFFF);
    write_reg(RegC, 24'hFF_FFFF);
    send_sample(16'd0);
    send_sample(16'd20000);
    send_sample(16'd32767);
    drain_pipe();
    write_reg(RegQuad, 32'h7FFF_FFFF);
    write_reg(RegB, 32'd0);
    write_reg(RegC, 24'd0);
    send_sample(16'd10000);
    send_sample(16'd32767);
    drain_pipe();
  endtask

  task automatic restore_defaults();
    write_reg(RegA, 32'd1024);
    write_reg(RegB, 32'd1199207);
    write_reg(RegC, 32'd13410);
    write_reg(RegQuad, 32'd0);
    write_reg(RegGain, 32'd63898);
    write_reg(RegOffset, 32'd262193);
    write_reg(RegSeries, 32'd100000);
  endtask

  // random settings near the sensor operating point, with random raw samples
  task automatic test_random_phases();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) restore_defaults();
      else begin
        write_reg(RegA, (ph == 5) ? $urandom : $urandom_range(200, 5000));
        write_reg(RegB, $urandom_range(700000, 1500000));
        write_reg(RegC, $urandom_range(0, 30000));
        write_reg(RegQuad, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 255));
        write_reg(RegGain, $urandom_range(50000, 80000));
        write_reg(RegOffset, $urandom_range(0, 1) ? 32'($urandom_range(0, 400000))
                                                   : $urandom);
        write_reg(RegSeries, $urandom_range(1000, 200000));
      end
      repeat (250) send_sample(rand_sample());
      drain_pipe();
    end
  endtask

  task automatic test_backpressure();
    restore_defaults();
    @(posedge clk_i);
    rx_hold = 300;                    // long hold-off so the pipe fills and stalls
    @(negedge clk_i);
    repeat (150) send_sample(rand_sample());
    drain_pipe();                     // sender pause until every result is back
    repeat (50) send_sample(rand_sample());
    drain_pipe();
  endtask

  task automatic test_full_rate();
    rx_idle_en = 1'b0;
    tx_idle_en = 1'b0;
    repeat (300) send_sample(rand_sample());
    drain_pipe();
  endtask

  initial begin
    a_q16 = 32'd1024; b_q8 = 32'd1199207; c_q8 = 24'd13410; quad_q32 = '0;
    gain_q16 = 18'd63898; offset_q8 = 24'd262193; series = 24'd100000;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);
    test_defaults();
    test_special_regs();
    restore_defaults();
    test_random_phases();
    test_backpressure();
    test_full_rate();
    if (temp_queue.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, temp_queue.size());
      n_errors++;
    end
    $display("sent %0d samples, checked %0d temperatures (%0d in range)",
             n_sent, n_temps, n_valid_temps);
    $display("covered register extremes, random settings, stalls and full rate");
    if (n_errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
